>>> hdl/tgi_pkg.sv
package tgi_pkg;

   localparam int COORD_W   = 32;
   localparam int TOL_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int FBITS     = 16;                 // fraction bits of a weight
   localparam int FRAC_W    = FBITS + 1;          // weight 0..65536
   localparam int CELL_W    = 8;                  // holds POINTS-1 up to 255
   localparam int QUO_W     = CELL_W + FBITS;     // cell and fraction from one divide
   localparam int DIVD_W    = COORD_W + CELL_W;   // (p-low)*(N-1)
   localparam int QCNT_W    = $clog2(QUO_W + 1);
   localparam int VAL_W     = 49;                 // x and y stage partial sums
   localparam int SPLIT     = 24;                 // operand split point
   localparam int OPND_W    = VAL_W - SPLIT + 1;  // signed half operand
   localparam int PROD_W    = FRAC_W + 1 + OPND_W;
   localparam int ACC_W     = 68;

   localparam int DEF_POINTS = 16;

   localparam logic [COORD_W-1:0] LOW_RESET  = 32'd0;
   localparam logic [COORD_W-1:0] HIGH_RESET = 32'd983040;
   localparam logic [TOL_W-1:0]   TOL_RESET  = 16'd1;
   localparam logic [FRAC_W-1:0]  ONE_WEIGHT = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = 3'd6;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STG_X,
      STG_Y,
      STG_Z
   } stage_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLAMP,
      S_MUL,
      S_DIV,
      S_FETCH,
      S_MLO,
      S_MHI,
      S_SAVE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic              en;
      logic              clr;
      logic              hi;
      logic [FRAC_W-1:0] weight;
   } mac_ctrl_type;

endpackage

>>> hdl/tgi_ram.sv
module tgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tgi_div.sv
module tgi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tgi_pkg::DIVD_W-1:0]    dividend,
   input  logic [tgi_pkg::COORD_W-1:0]   divisor,
   output logic                          done,
   output logic [tgi_pkg::QUO_W-1:0]     quotient
);
   import tgi_pkg::*;

   // Quotient of dividend * 2^16 / divisor, one bit per cycle. The quotient is
   // known to fit QUO_W bits, so the upper dividend bits seed the remainder.
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]   low_ff, low_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [COORD_W:0]   trial;
   logic [COORD_W:0]   shifted;

   always_comb begin
      shifted   = {rem_ff, low_ff[QUO_W-1]};
      trial     = shifted - {1'b0, divisor};
      rem_in    = rem_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = dividend[DIVD_W-1:CELL_W];
         low_in    = {dividend[CELL_W-1:0], {FBITS{1'b0}}};
         cnt_in    = QCNT_W'(QUO_W);
         active_in = 1'b1;
      end else if (active_ff) begin
         if (!trial[COORD_W]) begin
            rem_in = trial[COORD_W-1:0];
         end else begin
            rem_in = shifted[COORD_W-1:0];
         end
         quo_in = {quo_ff[QUO_W-2:0], ~trial[COORD_W]};
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - QCNT_W'(1);
         if (cnt_ff == QCNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/tgi_mac.sv
module tgi_mac (
   input  logic                          clock,
   input  tgi_pkg::mac_ctrl_type         ctrl,
   input  logic [tgi_pkg::VAL_W-1:0]     value,
   output logic [tgi_pkg::ACC_W-1:0]     acc
);
   import tgi_pkg::*;

   // One weight times one half of a 49-bit operand per cycle while ctrl.en is
   // set; the high half lands SPLIT bits up.
   logic signed [OPND_W-1:0] opnd;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      if (ctrl.hi) begin
         opnd = $signed({value[VAL_W-1], value[VAL_W-1:SPLIT]});
      end else begin
         opnd = $signed({{(OPND_W-SPLIT){1'b0}}, value[SPLIT-1:0]});
      end
      prod   = $signed({1'b0, ctrl.weight}) * opnd;
      addend = ctrl.hi ? (ACC_W'(prod) <<< SPLIT) : ACC_W'(prod);
      acc_in = acc_ff;
      if (ctrl.en) begin
         acc_in = (ctrl.clr ? '0 : acc_ff) + addend;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> hdl/trilinear_grid_interpolator.sv
// Trilinear interpolator over a POINTS_X x POINTS_Y x POINTS_Z grid of Q16.16
// samples held in one block RAM. A beat with req_tuser low writes one sample;
// a beat with req_tuser high queries a point and yields one result beat. A
// query snaps and clamps each coordinate, finds its cell and 17-bit fraction
// with a bit-serial divider, then reads the eight corners one at a time and
// folds them through a single shared 18x26 multiply-accumulate unit, each
// weighted term as a low half and then a high half. An axis runs a clamp, the
// dividend multiply, 24 divider steps and a hand-over of the quotient, or the
// clamp alone on an empty span or a point on the top bound. The x stage
// fetches each corner and multiplies it in two halves, with four saves; the y
// and z stages multiply saved sums without fetches, and the output load comes
// last. The next request is taken as soon as the result sits in the output
// register.
// Corners never written since reset read as undefined values.
module trilinear_grid_interpolator #(
   parameter int POINTS_X = tgi_pkg::DEF_POINTS,
   parameter int POINTS_Y = tgi_pkg::DEF_POINTS,
   parameter int POINTS_Z = tgi_pkg::DEF_POINTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // grid_x, grid_y, grid_z, entry_value, point_x, point_y, point_z, 4 zero pad bits
   input  logic [143:0]                    req_tdata,
   // req_type
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // interp_value
   output logic [31:0]                     rsp_tdata,
   // range_error
   output logic [0:0]                      rsp_tuser,
   input  logic                            csr_wen,
   input  logic [tgi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgi_pkg::COORD_W-1:0]     csr_wdata
);
   import tgi_pkg::*;

   localparam int GRID_DEPTH = POINTS_X * POINTS_Y * POINTS_Z;
   localparam int ADDR_W     = $clog2(GRID_DEPTH);
   localparam logic [ADDR_W-1:0] PY_A = ADDR_W'(POINTS_Y);
   localparam logic [ADDR_W-1:0] PZ_A = ADDR_W'(POINTS_Z);

   // configuration
   logic [COORD_W-1:0] low_ff  [3];
   logic [COORD_W-1:0] high_ff [3];
   logic [TOL_W-1:0]   tol_ff;

   // request fields
   logic [3:0]         grid_x, grid_y, grid_z;
   logic [COORD_W-1:0] entry_value;
   logic [COORD_W-1:0] point_in [3];

   assign grid_x      = req_tdata[3:0];
   assign grid_y      = req_tdata[7:4];
   assign grid_z      = req_tdata[11:8];
   assign entry_value = req_tdata[43:12];
   assign point_in[0] = req_tdata[75:44];
   assign point_in[1] = req_tdata[107:76];
   assign point_in[2] = req_tdata[139:108];

   state_type          state_ff, state_in;
   stage_type          stage_ff, stage_in;
   logic [1:0]         ax_ff, ax_in;
   logic [2:0]         m_ff, m_in;
   logic [COORD_W-1:0] p_ff [3];
   logic               err_ff, err_in;
   logic [CELL_W-1:0]  cell_ff [3];
   logic [CELL_W-1:0]  cell_in [3];
   logic [FRAC_W-1:0]  frac_ff [3];
   logic [FRAC_W-1:0]  frac_in [3];
   logic [COORD_W-1:0] d_ff, d_in;
   logic [COORD_W-1:0] span_ff, span_in;
   logic [VAL_W-1:0]   a_ff [4];
   logic [VAL_W-1:0]   b_ff [2];
   logic               save_a, save_b, save_r;
   logic [COORD_W-1:0] res_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_data_ff;
   logic               rsp_err_ff;
   logic               load_out;

   // axis setup
   logic [CELL_W-1:0]   nm1_sel;
   logic signed [33:0]  ps, los, his, pc, tols;
   logic                empty, outside;
   logic [COORD_W-1:0]  d_cmb, span_cmb;

   // units
   logic                div_start, div_done;
   logic [QUO_W-1:0]    quo;
   logic [DIVD_W-1:0]   t_cmb;
   mac_ctrl_type        mac_ctrl;
   logic [VAL_W-1:0]    mac_val;
   logic [ACC_W-1:0]    acc;
   logic [ACC_W-1:0]    acc_r16, acc_r32;
   logic signed [35:0]  r36;

   // RAM ports
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [COORD_W-1:0]  rd_data;
   logic [CELL_W-1:0]   ci, cj, ck;

   assign req_tready = (state_ff == S_IDLE);
   assign wr_en = req_tvalid && req_tready && (req_tuser[0] == REQ_WRITE)
                  && (32'(grid_x) < POINTS_X) && (32'(grid_y) < POINTS_Y)
                  && (32'(grid_z) < POINTS_Z);
   assign wr_addr = ((ADDR_W'(grid_x) * PY_A) + ADDR_W'(grid_y)) * PZ_A
                    + ADDR_W'(grid_z);

   // corner m = {dj, dk, dx} in the x stage
   assign ci = cell_ff[0] + CELL_W'(m_ff[0]);
   assign cj = cell_ff[1] + CELL_W'(m_ff[2]);
   assign ck = cell_ff[2] + CELL_W'(m_ff[1]);
   assign rd_addr = ((ADDR_W'(ci) * PY_A) + ADDR_W'(cj)) * PZ_A + ADDR_W'(ck);

   tgi_ram #(
      .WIDTH (COORD_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (ax_ff)
         2'd0:    nm1_sel = CELL_W'(POINTS_X - 1);
         2'd1:    nm1_sel = CELL_W'(POINTS_Y - 1);
         default: nm1_sel = CELL_W'(POINTS_Z - 1);
      endcase
      ps   = 34'(signed'(p_ff[ax_ff]));
      los  = 34'(signed'(low_ff[ax_ff]));
      his  = 34'(signed'(high_ff[ax_ff]));
      tols = $signed({18'd0, tol_ff});
      empty = (his <= los);
      pc = ps;
      if (ps > his && (ps - his) < tols) begin
         pc = his;
      end else if (ps < los && (los - ps) < tols) begin
         pc = los;
      end
      outside = (pc > his) || (pc < los);
      if (pc > his) begin
         pc = his;
      end else if (pc < los) begin
         pc = los;
      end
      d_cmb    = COORD_W'(pc - los);
      span_cmb = COORD_W'(his - los);
   end

   assign t_cmb     = DIVD_W'(d_ff) * DIVD_W'(nm1_sel);
   assign div_start = (state_ff == S_MUL);

   tgi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (t_cmb),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      case (stage_ff)
         STG_X:   mac_val = VAL_W'(signed'(rd_data));
         STG_Y:   mac_val = a_ff[{m_ff[0], m_ff[1]}];
         default: mac_val = b_ff[m_ff[0]];
      endcase
   end

   tgi_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .value (mac_val),
      .acc   (acc)
   );

   assign acc_r16 = acc + ACC_W'(1 << (FBITS - 1));
   assign acc_r32 = acc + (ACC_W'(1) << 31);
   assign r36     = $signed(acc_r32[67:32]);

   always_comb begin
      logic [FRAC_W-1:0] f_sel;
      case (stage_ff)
         STG_X:   f_sel = frac_ff[0];
         STG_Y:   f_sel = frac_ff[1];
         default: f_sel = frac_ff[2];
      endcase
      state_in     = state_ff;
      stage_in     = stage_ff;
      ax_in        = ax_ff;
      m_in         = m_ff;
      err_in       = err_ff;
      cell_in      = cell_ff;
      frac_in      = frac_ff;
      d_in         = d_ff;
      span_in      = span_ff;
      save_a       = 1'b0;
      save_b       = 1'b0;
      save_r       = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mac_ctrl.en     = 1'b0;
      mac_ctrl.clr    = !m_ff[0];
      mac_ctrl.hi     = 1'b0;
      mac_ctrl.weight = m_ff[0] ? f_sel : ONE_WEIGHT - f_sel;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tuser[0] == REQ_QUERY) begin
               ax_in    = 2'd0;
               err_in   = 1'b0;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (empty) begin
               cell_in[ax_ff] = '0;
               frac_in[ax_ff] = '0;
            end else begin
               err_in = err_ff | outside;
               cell_in[ax_ff] = nm1_sel - CELL_W'(1);
               frac_in[ax_ff] = ONE_WEIGHT;
               d_in    = d_cmb;
               span_in = span_cmb;
            end
            if (!empty && d_cmb != span_cmb) begin
               state_in = S_MUL;
            end else if (ax_ff == 2'd2) begin
               stage_in = STG_X;
               m_in     = '0;
               state_in = S_FETCH;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               cell_in[ax_ff] = quo[QUO_W-1:FBITS];
               frac_in[ax_ff] = {1'b0, quo[FBITS-1:0]};
               if (ax_ff == 2'd2) begin
                  stage_in = STG_X;
                  m_in     = '0;
                  state_in = S_FETCH;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_CLAMP;
               end
            end
         end
         S_FETCH: begin
            state_in = S_MLO;
         end
         S_MLO: begin
            mac_ctrl.en = 1'b1;
            state_in    = S_MHI;
         end
         S_MHI: begin
            mac_ctrl.en  = 1'b1;
            mac_ctrl.hi  = 1'b1;
            mac_ctrl.clr = 1'b0;
            if (m_ff[0]) begin
               state_in = S_SAVE;
            end else begin
               m_in     = m_ff + 3'd1;
               state_in = (stage_ff == STG_X) ? S_FETCH : S_MLO;
            end
         end
         S_SAVE: begin
            m_in = m_ff + 3'd1;
            case (stage_ff)
               STG_X: begin
                  save_a   = 1'b1;
                  state_in = S_FETCH;
                  if (m_ff == 3'd7) begin
                     stage_in = STG_Y;
                     m_in     = '0;
                     state_in = S_MLO;
                  end
               end
               STG_Y: begin
                  save_b   = 1'b1;
                  state_in = S_MLO;
                  if (m_ff == 3'd3) begin
                     stage_in = STG_Z;
                     m_in     = '0;
                  end
               end
               default: begin
                  save_r   = 1'b1;
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         low_ff[0]    <= LOW_RESET;
         low_ff[1]    <= LOW_RESET;
         low_ff[2]    <= LOW_RESET;
         high_ff[0]   <= HIGH_RESET;
         high_ff[1]   <= HIGH_RESET;
         high_ff[2]   <= HIGH_RESET;
         tol_ff       <= TOL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_X_LOW:  low_ff[0]  <= csr_wdata;
               CSR_X_HIGH: high_ff[0] <= csr_wdata;
               CSR_Y_LOW:  low_ff[1]  <= csr_wdata;
               CSR_Y_HIGH: high_ff[1] <= csr_wdata;
               CSR_Z_LOW:  low_ff[2]  <= csr_wdata;
               CSR_Z_HIGH: high_ff[2] <= csr_wdata;
               CSR_TOL:    tol_ff     <= csr_wdata[TOL_W-1:0];
               default:    ;
            endcase
         end
      end
      stage_ff <= stage_in;
      ax_ff    <= ax_in;
      m_ff     <= m_in;
      err_ff   <= err_in;
      cell_ff  <= cell_in;
      frac_ff  <= frac_in;
      d_ff     <= d_in;
      span_ff  <= span_in;
      if (state_ff == S_IDLE) begin
         p_ff <= point_in;
      end
      if (save_a) begin
         a_ff[m_ff[2:1]] <= acc[VAL_W-1:0];
      end
      if (save_b) begin
         b_ff[m_ff[1]] <= acc_r16[FBITS+VAL_W-1:FBITS];
      end
      if (save_r) begin
         if (r36 > 36'sd2147483647) begin
            res_ff <= 32'h7FFF_FFFF;
         end else if (r36 < -36'sd2147483648) begin
            res_ff <= 32'h8000_0000;
         end else begin
            res_ff <= r36[31:0];
         end
      end
      if (load_out) begin
         rsp_data_ff <= res_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule

>>> test/trilinear_grid_interpolator_tb.sv
`timescale 1ns / 1ps

module trilinear_grid_interpolator_tb;
   import tgi_pkg::*;

   localparam int NPTS = DEF_POINTS;

   typedef struct {
      logic [31:0] value;
      logic        clamped;
   } interp_result_type;

   class interp_scoreboard;
      logic [31:0]       grid [0:NPTS*NPTS*NPTS-1];
      logic [31:0]       bound [0:5];
      logic [15:0]       tol;
      interp_result_type pending_q [$];
      int                errors;

      function new();
         errors = 0;
         for (int r = 0; r < 6; r++)
            bound[r] = (r % 2 == 0) ? LOW_RESET : HIGH_RESET;
         tol = TOL_RESET;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         if (idx == CSR_TOL)
            tol = val[15:0];
         else
            bound[idx] = val;
      endfunction

      function void locate(longint p, longint lo, longint hi, output int cell_idx,
                           output longint frac, inout bit err);
         longint span, t, idx;
         cell_idx = 0;
         frac = 0;
         if (hi <= lo) return;
         if (p > hi && p - hi < tol) p = hi;
         else if (p < lo && lo - p < tol) p = lo;
         if (p > hi) begin
            p = hi;
            err = 1;
         end else if (p < lo) begin
            p = lo;
            err = 1;
         end
         span = hi - lo;
         t = (p - lo) * (NPTS - 1);
         idx = t / span;
         if (idx > NPTS - 2) idx = NPTS - 2;
         cell_idx = int'(idx);
         frac = ((t - idx * span) * 65536) / span;
      endfunction

      function longint corner(int i, int j, int k);
         return longint'($signed(grid[(i * NPTS + j) * NPTS + k]));
      endfunction

      function void note_request(logic typ, logic [143:0] d);
         int ci, cj, ck;
         longint fx, fy, fz, a [2][2], b [2], c, r;
         bit err;
         interp_result_type res;
         if (typ == REQ_WRITE) begin
            grid[{d[3:0], d[7:4], d[11:8]}] = d[43:12];
            return;
         end
         err = 0;
         locate($signed(d[75:44]), $signed(bound[0]), $signed(bound[1]), ci, fx, err);
         locate($signed(d[107:76]), $signed(bound[2]), $signed(bound[3]), cj, fy, err);
         locate($signed(d[139:108]), $signed(bound[4]), $signed(bound[5]), ck, fz, err);
         for (int dj = 0; dj < 2; dj++)
            for (int dk = 0; dk < 2; dk++)
               a[dj][dk] = (65536 - fx) * corner(ci, cj + dj, ck + dk)
                         + fx * corner(ci + 1, cj + dj, ck + dk);
         for (int dk = 0; dk < 2; dk++)
            b[dk] = ((65536 - fy) * a[0][dk] + fy * a[1][dk] + 32768) >>> 16;
         c = (65536 - fz) * b[0] + fz * b[1];
         r = (c + 64'sd2147483648) >>> 32;
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         res.value = r[31:0];
         res.clamped = err;
         pending_q.push_back(res);
      endfunction

      function void check_result(logic [31:0] value, logic clamped);
         interp_result_type exp_res;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: value %h clamped %b", value, clamped);
            return;
         end
         exp_res = pending_q.pop_front();
         if (value !== exp_res.value || clamped !== exp_res.clamped) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected value %h clamped %b, got value %h clamped %b",
                        exp_res.value, exp_res.clamped, value, clamped);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [143:0]       req_tdata;
   logic [0:0]         req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [31:0]        rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0] csr_wdata;

   interp_scoreboard interp_sb;
   bit               quiet_phase;

   trilinear_grid_interpolator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [143:0] pack_beat(logic [3:0] gx, gy, gz,
                                              logic [31:0] val, px, py, pz);
      return {4'b0, pz, py, px, val, gz, gy, gx};
   endfunction

   // pick a coordinate near or inside the configured range of one axis, or a random one
   function automatic logic [31:0] pick_coord(int axis);
      longint lo, hi, span;
      int r;
      lo = $signed(interp_sb.bound[2 * axis]);
      hi = $signed(interp_sb.bound[2 * axis + 1]);
      span = hi - lo;
      r = $urandom_range(0, 19);
      case (r)
         0: return clip32(lo);
         1: return clip32(hi);
         2: return clip32(hi + $urandom_range(0, 70000));
         3: return clip32(lo - $urandom_range(0, 70000));
         4: return $urandom;
         5: return clip32(hi + longint'(interp_sb.tol) - $urandom_range(0, 1));
         default: begin
            if (span <= 0) return clip32(lo + $signed($urandom_range(0, 200)) - 100);
            return clip32(lo + ((span * $urandom_range(0, 65535)) >>> 16)
                          + $urandom_range(0, 3));
         end
      endcase
   endfunction

   task automatic send_beat(logic typ, logic [143:0] d);
      int g;
      g = idle_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= typ;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      interp_sb.note_request(typ, d);
   endtask

   task automatic send_query(logic [31:0] px, py, pz);
      send_beat(REQ_QUERY, pack_beat(4'($urandom), 4'($urandom), 4'($urandom), $urandom,
                                     px, py, pz));
   endtask

   task automatic send_write(logic [3:0] gx, gy, gz, logic [31:0] val);
      send_beat(REQ_WRITE, pack_beat(gx, gy, gz, val, $urandom, $urandom, $urandom));
   endtask

   // hold the request side until every expected result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (interp_sb.pending_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic load_bounds(logic [31:0] regs [0:6]);
      for (int i = 0; i < 7; i++) begin
         csr_wen <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= regs[i];
         @(posedge clock);
         interp_sb.set_reg(CSR_IDX_W'(i), regs[i]);
      end
      csr_wen <= 1'b0;
   endtask

   task automatic random_traffic(int n);
      logic [31:0] val;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: val = 32'h7fffffff;
               1: val = 32'h80000000;
               default: val = $urandom;
            endcase
            send_write(4'($urandom), 4'($urandom), 4'($urandom), val);
         end else
            send_query(pick_coord(0), pick_coord(1), pick_coord(2));
      end
   endtask

   initial begin
      logic [31:0] regs [0:6];
      longint lo, w;
      interp_sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_phase = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every grid entry so no query can touch an unwritten corner
      for (int e = 0; e < NPTS * NPTS * NPTS; e++)
         send_write(e[11:8], e[7:4], e[3:0], $urandom);
      quiet_phase = 1'b0;

      // reset bounds: grid corners, top edge, far outside, half-cell points
      send_write(4'd0, 4'd0, 4'd0, 32'h7fffffff);
      send_write(4'd15, 4'd15, 4'd15, 32'h80000000);
      send_query(32'd0, 32'd0, 32'd0);
      send_query(32'd983040, 32'd983040, 32'd983040);
      send_query(32'h80000000, 32'h7fffffff, 32'hffffffff);
      send_query(32'h00008000, 32'h00018000, 32'h000e8000);
      send_query(32'd983041, 32'hffffffff, 32'd12345);
      send_query(32'h7fffffff, 32'h80000000, 32'd983039);
      drain();

      // widest span with the largest tolerance
      regs = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h0000ffff};
      load_bounds(regs);
      send_query(32'h80000000, 32'h7fffffff, 32'h00000000);
      send_query(32'h7fffffff, 32'h80000001, 32'hc0000000);
      random_traffic(150);
      drain();

      // zero tolerance, one-step span, empty and reversed spans
      regs = '{32'h00010000, 32'h00010001, 32'h00050000, 32'h00050000,
               32'h00020000, 32'hfff00000, 32'h00000000};
      load_bounds(regs);
      send_query(32'h0000ffff, 32'h7fffffff, 32'h80000000);
      send_query(32'h00010002, 32'h00050000, 32'h00020000);
      send_query(32'h00010001, 32'h00000000, 32'h00000000);
      random_traffic(150);
      drain();

      // snapping just outside with a moderate tolerance
      regs = '{32'hfff00000, 32'h00100000, 32'h00000000, 32'h000f0000,
               32'hffff0000, 32'h00000100, 32'h00000100};
      load_bounds(regs);
      send_query(32'h001000ff, 32'hffffff01, 32'h000001ff);
      send_query(32'h00100100, 32'hffffff00, 32'hfffeff00);
      random_traffic(150);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         quiet_phase = (ph == 2);
         for (int ax = 0; ax < 3; ax++) begin
            case ($urandom_range(0, 4))
               0: begin
                  lo = $signed($urandom);
                  w = $urandom;
               end
               1: begin
                  lo = 0;
                  w = 0;
               end
               2: begin
                  lo = $signed($urandom) >>> 8;
                  w = $urandom_range(1, 64);
               end
               default: begin
                  lo = $signed($urandom) >>> 4;
                  w = $urandom_range(1, 32'h01000000);
               end
            endcase
            regs[2 * ax] = lo[31:0];
            regs[2 * ax + 1] = clip32(lo + w);
         end
         case ($urandom_range(0, 3))
            0: regs[6] = 32'd0;
            1: regs[6] = 32'd65535;
            default: regs[6] = $urandom_range(0, 65535);
         endcase
         load_bounds(regs);
         random_traffic(150);
         drain();
      end

      req_tvalid <= 1'b0;
      repeat (200) @(posedge clock);
      if (interp_sb.errors == 0 && interp_sb.pending_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int g;
      @(negedge reset);
      forever begin
         g = idle_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid)
            interp_sb.check_result(rsp_tdata, rsp_tuser[0]);
      end
   end

endmodule

>>> trilinear_grid_interpolator.f
hdl/tgi_pkg.sv
hdl/tgi_ram.sv
hdl/tgi_div.sv
hdl/tgi_mac.sv
hdl/trilinear_grid_interpolator.sv
test/trilinear_grid_interpolator_tb.sv
